[hw/rtl/terminal_key_sequence_decoder_assert.svh]
// Assertion macros shared by the checker of the terminal key sequence decoder.
`ifndef TERMINAL_KEY_SEQUENCE_DECODER_ASSERT_SVH
`define TERMINAL_KEY_SEQUENCE_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TKSD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tksd assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define TKSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tksd assertion failed in the following cycle");

`endif

[hw/rtl/tksd_pkg.sv]
// Types, constants and helper functions of the terminal key sequence decoder.
package tksd_pkg;

    typedef logic [4:0]  t_seq_len;
    typedef logic [19:0] t_ticks;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic KIND_KEY     = 1'b0;
    localparam logic KIND_INVALID = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] key_value;
        logic       ctrl_flag;
        logic       alt_flag;
        logic       special_flag;
        logic [7:0] xterm_modifiers;
        t_seq_len   sequence_length;
    } t_out_item;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_BAD    = 2'd2
    } t_param_phase;

    localparam t_ticks TIMEOUT_RESET = 20'd10000;
    localparam t_ticks TICK_MAX      = 20'hFFFFF;

    localparam logic [7:0] NUL_BYTE   = 8'd0;
    localparam logic [7:0] CTRL_FIRST = 8'd1;
    localparam logic [7:0] CTRL_LAST  = 8'd26;
    localparam logic [7:0] ESC_BYTE   = 8'd27;
    localparam logic [7:0] FS_BYTE    = 8'd28;
    localparam logic [7:0] US_BYTE    = 8'd31;
    localparam logic [7:0] PRINT_LO   = 8'h20;
    localparam logic [7:0] PRINT_HI   = 8'h7E;
    localparam logic [7:0] DEL_BYTE   = 8'd127;
    localparam logic [7:0] CSI_BYTE   = 8'h5B;
    localparam logic [7:0] SEP_BYTE   = 8'h3B;
    localparam logic [7:0] TILDE_BYTE = 8'h7E;
    localparam logic [7:0] FINAL_LO   = 8'h40;
    localparam logic [7:0] DIGIT_0    = 8'h30;
    localparam logic [7:0] DIGIT_9    = 8'h39;
    localparam logic [7:0] UPPER_A    = 8'h41;
    localparam logic [7:0] UPPER_Z    = 8'h5A;
    localparam logic [7:0] CTRL_BASE  = 8'h40;
    localparam logic [7:0] NUL_KEY    = 8'h60;

    localparam logic [7:0] SK_UNKNOWN   = 8'd0;
    localparam logic [7:0] SK_ESC       = 8'd1;
    localparam logic [7:0] SK_HOME      = 8'd2;
    localparam logic [7:0] SK_END       = 8'd5;
    localparam logic [7:0] SK_UP        = 8'd29;
    localparam logic [7:0] SK_DOWN      = 8'd30;
    localparam logic [7:0] SK_RIGHT     = 8'd31;
    localparam logic [7:0] SK_LEFT      = 8'd32;
    localparam logic [7:0] SK_KEYPAD_5  = 8'd33;
    localparam logic [7:0] SK_BACKSPACE = 8'd34;

    localparam logic [7:0] PARAM_MAX = 8'd255;

    function automatic logic [7:0] add_digit(input logic [7:0] v, input logic [3:0] d);
        logic [11:0] s;
        s = ({4'b0, v} * 12'd10) + {8'b0, d};
        return (s > {4'b0, PARAM_MAX}) ? PARAM_MAX : s[7:0];
    endfunction

    function automatic logic [7:0] less_one(input logic [7:0] m);
        return (m != 8'd0) ? (m - 8'd1) : 8'd0;
    endfunction

    function automatic logic [7:0] vt_key(input logic [7:0] p);
        logic [7:0] k;
        unique case (p)
            8'd1:    k = 8'd2;
            8'd2:    k = 8'd3;
            8'd3:    k = 8'd4;
            8'd4:    k = 8'd5;
            8'd5:    k = 8'd6;
            8'd6:    k = 8'd7;
            8'd7:    k = 8'd2;
            8'd8:    k = 8'd5;
            8'd10:   k = 8'd8;
            8'd11:   k = 8'd9;
            8'd12:   k = 8'd10;
            8'd13:   k = 8'd11;
            8'd14:   k = 8'd12;
            8'd15:   k = 8'd13;
            8'd17:   k = 8'd14;
            8'd18:   k = 8'd15;
            8'd19:   k = 8'd16;
            8'd20:   k = 8'd17;
            8'd21:   k = 8'd18;
            8'd23:   k = 8'd19;
            8'd24:   k = 8'd20;
            8'd25:   k = 8'd21;
            8'd26:   k = 8'd22;
            8'd28:   k = 8'd23;
            8'd29:   k = 8'd24;
            8'd31:   k = 8'd25;
            8'd32:   k = 8'd26;
            8'd33:   k = 8'd27;
            8'd34:   k = 8'd28;
            default: k = SK_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] xterm_key(input logic [7:0] c);
        logic [7:0] k;
        unique case (c)
            8'h41:   k = SK_UP;
            8'h42:   k = SK_DOWN;
            8'h43:   k = SK_RIGHT;
            8'h44:   k = SK_LEFT;
            8'h46:   k = SK_END;
            8'h47:   k = SK_KEYPAD_5;
            8'h48:   k = SK_HOME;
            default: k = SK_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

[hw/rtl/terminal_key_sequence_decoder.sv]
// Terminal key sequence decoder: one byte or tick per beat, at most one key per beat.
// A result reaches the output register in the cycle after its input beat is taken.
// One beat per cycle unless stalled; the parse state registers update in one pass.
// An input beat is taken whenever the output register is empty or being drained.
// Synchronous active-low reset clears the parse state and idle count, empties the
// output register and sets the escape timeout to 10000 ticks.
module terminal_key_sequence_decoder #(
    parameter int SEQ_CAPACITY = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tksd_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tksd_pkg::t_out_item o_out,
    input  logic                i_cfg_we,
    input  tksd_pkg::t_ticks    i_cfg_wdata
);

    localparam int CNT_W = $clog2(SEQ_CAPACITY + 1);

    logic [CNT_W-1:0]       r_count, n_count;
    logic [7:0]             r_lead, n_lead;
    logic [7:0]             r_second, n_second;
    logic [7:0]             r_first_param, n_first_param;
    logic [7:0]             r_second_param, n_second_param;
    logic                   r_slot, n_slot;
    tksd_pkg::t_param_phase r_phase, n_phase;
    tksd_pkg::t_ticks       r_idle, n_idle;
    tksd_pkg::t_ticks       r_timeout;
    logic                   r_out_valid;
    tksd_pkg::t_out_item    r_out, n_out;
    logic                   emit;
    logic                   accept;
    logic [CNT_W-1:0]       cnt;
    logic [7:0]             b;
    logic [7:0]             lead;
    logic [7:0]             second;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign b      = i_in.data_byte;
    assign cnt    = r_count + CNT_W'(1);
    assign lead   = (cnt == CNT_W'(1)) ? b : r_lead;
    assign second = (cnt == CNT_W'(2)) ? b : r_second;

    function automatic tksd_pkg::t_out_item make_out(
        input logic       kind,
        input logic [7:0] code,
        input logic       ctrl,
        input logic       alt,
        input logic       special,
        input logic [7:0] mods,
        input logic [CNT_W-1:0] len
    );
        tksd_pkg::t_out_item o;
        o.result_kind     = kind;
        o.key_value       = code;
        o.ctrl_flag       = ctrl;
        o.alt_flag        = alt;
        o.special_flag    = special;
        o.xterm_modifiers = mods;
        o.sequence_length = tksd_pkg::t_seq_len'(len);
        return o;
    endfunction

    always_comb begin
        n_count        = r_count;
        n_lead         = r_lead;
        n_second       = r_second;
        n_first_param  = r_first_param;
        n_second_param = r_second_param;
        n_slot         = r_slot;
        n_phase        = r_phase;
        n_idle         = r_idle;
        emit           = 1'b0;
        n_out          = make_out(tksd_pkg::KIND_KEY, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0, cnt);

        if (i_in.opcode == tksd_pkg::OP_TICK) begin
            n_idle = (r_idle != tksd_pkg::TICK_MAX) ? (r_idle + 20'd1) : r_idle;
            if (n_idle > r_timeout) begin
                if (r_count == CNT_W'(1) && r_lead == tksd_pkg::ESC_BYTE) begin
                    emit  = 1'b1;
                    n_out = make_out(tksd_pkg::KIND_KEY, tksd_pkg::SK_ESC, 1'b0, 1'b0,
                                     1'b1, 8'd0, CNT_W'(1));
                end else if (r_count == CNT_W'(2) && r_lead == tksd_pkg::ESC_BYTE &&
                             r_second == tksd_pkg::CSI_BYTE) begin
                    emit  = 1'b1;
                    n_out = make_out(tksd_pkg::KIND_KEY, tksd_pkg::CSI_BYTE, 1'b0, 1'b1,
                                     1'b0, 8'd0, CNT_W'(2));
                end
            end
        end else begin
            n_idle   = '0;
            n_count  = cnt;
            n_lead   = lead;
            n_second = second;
            if ({{(32-CNT_W){1'b0}}, cnt} >= 32'(SEQ_CAPACITY)) begin
                emit  = 1'b1;
                n_out = make_out(tksd_pkg::KIND_INVALID, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0, cnt);
            end else if (cnt == CNT_W'(1)) begin
                if (b == tksd_pkg::NUL_BYTE) begin
                    emit  = 1'b1;
                    n_out = make_out(tksd_pkg::KIND_KEY, tksd_pkg::NUL_KEY, 1'b1, 1'b0,
                                     1'b0, 8'd0, cnt);
                end else if (b <= tksd_pkg::CTRL_LAST) begin
                    emit  = 1'b1;
                    n_out = make_out(tksd_pkg::KIND_KEY, b + tksd_pkg::CTRL_BASE, 1'b1,
                                     1'b0, 1'b0, 8'd0, cnt);
                end else if (b >= tksd_pkg::FS_BYTE && b <= tksd_pkg::US_BYTE) begin
                    emit  = 1'b1;
                    n_out = make_out(tksd_pkg::KIND_KEY, b, 1'b0, 1'b0, 1'b1, 8'd0, cnt);
                end else if (b >= tksd_pkg::PRINT_LO && b <= tksd_pkg::PRINT_HI) begin
                    emit  = 1'b1;
                    n_out = make_out(tksd_pkg::KIND_KEY, b, 1'b0, 1'b0, 1'b0, 8'd0, cnt);
                end else if (b == tksd_pkg::DEL_BYTE) begin
                    emit  = 1'b1;
                    n_out = make_out(tksd_pkg::KIND_KEY, tksd_pkg::SK_BACKSPACE, 1'b0,
                                     1'b0, 1'b1, 8'd0, cnt);
                end
            end else if (lead == tksd_pkg::ESC_BYTE) begin
                if (cnt == CNT_W'(2)) begin
                    if (b >= tksd_pkg::CTRL_FIRST && b <= tksd_pkg::CTRL_LAST) begin
                        emit  = 1'b1;
                        n_out = make_out(tksd_pkg::KIND_KEY, b + tksd_pkg::CTRL_BASE, 1'b1,
                                         1'b1, 1'b0, 8'd0, cnt);
                    end else if (b != tksd_pkg::CSI_BYTE) begin
                        emit  = 1'b1;
                        n_out = make_out(tksd_pkg::KIND_KEY, b, 1'b0, 1'b1, 1'b0, 8'd0, cnt);
                    end
                end else if (second == tksd_pkg::CSI_BYTE) begin
                    if (b >= tksd_pkg::FINAL_LO && b <= tksd_pkg::TILDE_BYTE) begin
                        emit = 1'b1;
                        if (r_phase != tksd_pkg::PH_BAD && b == tksd_pkg::TILDE_BYTE) begin
                            n_out = make_out(tksd_pkg::KIND_KEY,
                                             tksd_pkg::vt_key(r_first_param), 1'b0, 1'b0,
                                             1'b1, tksd_pkg::less_one(r_second_param), cnt);
                        end else if (r_phase != tksd_pkg::PH_BAD &&
                                     b >= tksd_pkg::UPPER_A && b <= tksd_pkg::UPPER_Z) begin
                            n_out = make_out(tksd_pkg::KIND_KEY, tksd_pkg::xterm_key(b),
                                             1'b0, 1'b0, 1'b1,
                                             tksd_pkg::less_one(r_first_param), cnt);
                        end else begin
                            n_out = make_out(tksd_pkg::KIND_INVALID, 8'd0, 1'b0, 1'b0,
                                             1'b0, 8'd0, cnt);
                        end
                    end else if (r_phase != tksd_pkg::PH_BAD &&
                                 b >= tksd_pkg::DIGIT_0 && b <= tksd_pkg::DIGIT_9) begin
                        if (!r_slot) begin
                            n_first_param = tksd_pkg::add_digit(r_first_param,
                                                                4'(b - tksd_pkg::DIGIT_0));
                        end else begin
                            n_second_param = tksd_pkg::add_digit(r_second_param,
                                                                 4'(b - tksd_pkg::DIGIT_0));
                        end
                    end else if (r_phase == tksd_pkg::PH_FIRST &&
                                 b == tksd_pkg::SEP_BYTE) begin
                        n_slot  = (r_first_param != 8'd0);
                        n_phase = tksd_pkg::PH_SECOND;
                    end else begin
                        n_phase = tksd_pkg::PH_BAD;
                    end
                end
            end
        end

        if (emit) begin
            n_count        = '0;
            n_lead         = '0;
            n_second       = '0;
            n_first_param  = '0;
            n_second_param = '0;
            n_slot         = 1'b0;
            n_phase        = tksd_pkg::PH_FIRST;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count        <= '0;
            r_lead         <= '0;
            r_second       <= '0;
            r_first_param  <= '0;
            r_second_param <= '0;
            r_slot         <= 1'b0;
            r_phase        <= tksd_pkg::PH_FIRST;
            r_idle         <= '0;
        end else if (accept) begin
            r_count        <= n_count;
            r_lead         <= n_lead;
            r_second       <= n_second;
            r_first_param  <= n_first_param;
            r_second_param <= n_second_param;
            r_slot         <= n_slot;
            r_phase        <= n_phase;
            r_idle         <= n_idle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= tksd_pkg::TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_out <= n_out;
        end
    end

endmodule

[hw/rtl/tksd_checker.sv]
// Port-level checker of the terminal key sequence decoder and its bind.
`include "terminal_key_sequence_decoder_assert.svh"

module tksd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input tksd_pkg::t_out_item o_out
);

    logic out_stalled;
    logic out_invalid;
    logic invalid_clean;
    logic out_special;
    logic out_has_mods;

    assign out_stalled   = o_out_valid && !i_out_ready;
    assign out_invalid   = o_out_valid && o_out.result_kind == tksd_pkg::KIND_INVALID;
    assign invalid_clean = o_out.key_value == 8'd0 && !o_out.ctrl_flag && !o_out.alt_flag &&
                           !o_out.special_flag && o_out.xterm_modifiers == 8'd0;
    assign out_special   = o_out_valid && o_out.special_flag;
    assign out_has_mods  = o_out_valid && o_out.xterm_modifiers != 8'd0;

    `TKSD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stalled, o_out_valid && $stable(o_out))
    `TKSD_ASSERT_SAME(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready)
    `TKSD_ASSERT_SAME(a_invalid_clean, i_clk, i_rst_n, out_invalid, invalid_clean)
    `TKSD_ASSERT_SAME(a_special_plain, i_clk, i_rst_n, out_special, !o_out.ctrl_flag && !o_out.alt_flag)
    `TKSD_ASSERT_SAME(a_mods_special, i_clk, i_rst_n, out_has_mods, o_out.special_flag)

endmodule

bind terminal_key_sequence_decoder tksd_checker u_tksd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

[sim/tb_top.sv]
// Self-checking testbench for the terminal key sequence decoder.
`timescale 1ns / 100ps

module tb_top;

    localparam int SEQ_CAP = 16;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    tksd_pkg::t_in_item  in_item = '0;
    logic                out_ready = 1'b0;
    logic                cfg_we = 1'b0;
    tksd_pkg::t_ticks    cfg_wdata = '0;
    logic                calm = 1'b0;
    logic                squeeze_req = 1'b0;
    wire                 in_ready;
    wire                 out_valid;
    tksd_pkg::t_out_item out_key;

    tksd_pkg::t_in_item  tx_beats [$];
    tksd_pkg::t_out_item keys_due [$];
    int        beats_queued = 0;
    int        beats_taken = 0;
    int        send_gap = 0;
    int        stall_left = 0;
    bit        squeeze_done = 1'b0;
    int        fail_count = 0;

    // Shadow copy of the decoder state.
    tksd_pkg::t_ticks       esc_timeout = tksd_pkg::TIMEOUT_RESET;
    int                     idle_count = 0;
    int                     seq_count = 0;
    logic [7:0]             lead_q = '0;
    logic [7:0]             second_q = '0;
    logic [7:0]             num_first = '0;
    logic [7:0]             num_second = '0;
    logic                   num_slot = 1'b0;
    tksd_pkg::t_param_phase num_phase = tksd_pkg::PH_FIRST;

    terminal_key_sequence_decoder #(
        .SEQ_CAPACITY(SEQ_CAP)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_key),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    function automatic logic [7:0] append_digit(input logic [7:0] acc, input int d);
        int v;
        v = int'(acc) * 10 + d;
        return (v > int'(tksd_pkg::PARAM_MAX)) ? tksd_pkg::PARAM_MAX : 8'(v);
    endfunction

    function automatic logic [7:0] minus_one(input logic [7:0] m);
        return (m == 8'd0) ? 8'd0 : m - 8'd1;
    endfunction

    function automatic logic [7:0] vt_lookup(input logic [7:0] p);
        if (p >= 1 && p <= 6) return p + 8'd1;
        if (p == 7) return tksd_pkg::SK_HOME;
        if (p == 8) return tksd_pkg::SK_END;
        if (p >= 10 && p <= 15) return p - 8'd2;
        if (p >= 17 && p <= 21) return p - 8'd3;
        if (p >= 23 && p <= 26) return p - 8'd4;
        if (p == 28 || p == 29) return p - 8'd5;
        if (p >= 31 && p <= 34) return p - 8'd6;
        return tksd_pkg::SK_UNKNOWN;
    endfunction

    function automatic logic [7:0] xterm_lookup(input logic [7:0] c);
        case (c)
            "A":     return tksd_pkg::SK_UP;
            "B":     return tksd_pkg::SK_DOWN;
            "C":     return tksd_pkg::SK_RIGHT;
            "D":     return tksd_pkg::SK_LEFT;
            "F":     return tksd_pkg::SK_END;
            "G":     return tksd_pkg::SK_KEYPAD_5;
            "H":     return tksd_pkg::SK_HOME;
            default: return tksd_pkg::SK_UNKNOWN;
        endcase
    endfunction

    function automatic tksd_pkg::t_out_item close_seq(input logic kind,
                                                      input logic [7:0] code,
                                                      input logic ctrl, input logic alt,
                                                      input logic special,
                                                      input logic [7:0] mods,
                                                      input int len);
        tksd_pkg::t_out_item key;
        key.result_kind = kind;
        key.key_value = code;
        key.ctrl_flag = ctrl;
        key.alt_flag = alt;
        key.special_flag = special;
        key.xterm_modifiers = mods;
        key.sequence_length = tksd_pkg::t_seq_len'(len);
        seq_count = 0;
        lead_q = '0;
        second_q = '0;
        num_first = '0;
        num_second = '0;
        num_slot = 1'b0;
        num_phase = tksd_pkg::PH_FIRST;
        return key;
    endfunction

    function automatic bit decode_beat(input tksd_pkg::t_in_item beat,
                                       output tksd_pkg::t_out_item key);
        logic [7:0] b;
        key = '0;
        if (beat.opcode == tksd_pkg::OP_TICK) begin
            if (idle_count < int'(tksd_pkg::TICK_MAX)) idle_count++;
            if (idle_count > int'(esc_timeout) && lead_q == tksd_pkg::ESC_BYTE) begin
                if (seq_count == 1) begin
                    key = close_seq(tksd_pkg::KIND_KEY, tksd_pkg::SK_ESC, 1'b0, 1'b0, 1'b1,
                                    8'd0, 1);
                    return 1'b1;
                end
                if (seq_count == 2 && second_q == tksd_pkg::CSI_BYTE) begin
                    key = close_seq(tksd_pkg::KIND_KEY, tksd_pkg::CSI_BYTE, 1'b0, 1'b1,
                                    1'b0, 8'd0, 2);
                    return 1'b1;
                end
            end
            return 1'b0;
        end
        b = beat.data_byte;
        idle_count = 0;
        seq_count++;
        if (seq_count == 1) lead_q = b;
        else if (seq_count == 2) second_q = b;
        if (seq_count >= SEQ_CAP) begin
            key = close_seq(tksd_pkg::KIND_INVALID, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0, seq_count);
            return 1'b1;
        end
        if (seq_count == 1) begin
            if (b == tksd_pkg::NUL_BYTE)
                key = close_seq(tksd_pkg::KIND_KEY, tksd_pkg::NUL_KEY, 1'b1, 1'b0, 1'b0,
                                8'd0, 1);
            else if (b <= tksd_pkg::CTRL_LAST)
                key = close_seq(tksd_pkg::KIND_KEY, b + tksd_pkg::CTRL_BASE, 1'b1, 1'b0,
                                1'b0, 8'd0, 1);
            else if (b >= tksd_pkg::FS_BYTE && b <= tksd_pkg::US_BYTE)
                key = close_seq(tksd_pkg::KIND_KEY, b, 1'b0, 1'b0, 1'b1, 8'd0, 1);
            else if (b >= tksd_pkg::PRINT_LO && b <= tksd_pkg::PRINT_HI)
                key = close_seq(tksd_pkg::KIND_KEY, b, 1'b0, 1'b0, 1'b0, 8'd0, 1);
            else if (b == tksd_pkg::DEL_BYTE)
                key = close_seq(tksd_pkg::KIND_KEY, tksd_pkg::SK_BACKSPACE, 1'b0, 1'b0,
                                1'b1, 8'd0, 1);
            else return 1'b0;
            return 1'b1;
        end
        if (lead_q != tksd_pkg::ESC_BYTE) return 1'b0;
        if (seq_count == 2) begin
            if (b >= tksd_pkg::CTRL_FIRST && b <= tksd_pkg::CTRL_LAST)
                key = close_seq(tksd_pkg::KIND_KEY, b + tksd_pkg::CTRL_BASE, 1'b1, 1'b1,
                                1'b0, 8'd0, 2);
            else if (b != tksd_pkg::CSI_BYTE)
                key = close_seq(tksd_pkg::KIND_KEY, b, 1'b0, 1'b1, 1'b0, 8'd0, 2);
            else return 1'b0;
            return 1'b1;
        end
        if (second_q != tksd_pkg::CSI_BYTE) return 1'b0;
        if (b >= tksd_pkg::FINAL_LO && b <= tksd_pkg::TILDE_BYTE) begin
            if (num_phase != tksd_pkg::PH_BAD && b == tksd_pkg::TILDE_BYTE)
                key = close_seq(tksd_pkg::KIND_KEY, vt_lookup(num_first), 1'b0, 1'b0, 1'b1,
                                minus_one(num_second), seq_count);
            else if (num_phase != tksd_pkg::PH_BAD &&
                     b >= tksd_pkg::UPPER_A && b <= tksd_pkg::UPPER_Z)
                key = close_seq(tksd_pkg::KIND_KEY, xterm_lookup(b), 1'b0, 1'b0, 1'b1,
                                minus_one(num_first), seq_count);
            else
                key = close_seq(tksd_pkg::KIND_INVALID, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0,
                                seq_count);
            return 1'b1;
        end
        if (num_phase != tksd_pkg::PH_BAD &&
            b >= tksd_pkg::DIGIT_0 && b <= tksd_pkg::DIGIT_9) begin
            if (num_slot) num_second = append_digit(num_second, int'(b - tksd_pkg::DIGIT_0));
            else num_first = append_digit(num_first, int'(b - tksd_pkg::DIGIT_0));
        end else if (num_phase == tksd_pkg::PH_FIRST && b == tksd_pkg::SEP_BYTE) begin
            num_slot = (num_first != 8'd0);
            num_phase = tksd_pkg::PH_SECOND;
        end else begin
            num_phase = tksd_pkg::PH_BAD;
        end
        return 1'b0;
    endfunction

    always @(posedge clk) begin
        tksd_pkg::t_out_item key;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                beats_taken <= beats_taken + 1;
                if (decode_beat(in_item, key)) keys_due.push_back(key);
            end
            if (!in_valid || in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(0, 14);
                    in_valid <= 1'b0;
                end else if (tx_beats.size() != 0) begin
                    in_valid <= 1'b1;
                    in_item <= tx_beats.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (squeeze_req && !squeeze_done) begin
            squeeze_done = 1'b1;
            stall_left = 299;
            out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 14);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk) begin
        tksd_pkg::t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (keys_due.size() == 0) begin
                $error("key beat arrived with none outstanding: %h", out_key);
                fail_count++;
            end else begin
                want = keys_due.pop_front();
                compare_field("result_kind", want.result_kind, out_key.result_kind);
                compare_field("key_value", want.key_value, out_key.key_value);
                compare_field("ctrl_flag", want.ctrl_flag, out_key.ctrl_flag);
                compare_field("alt_flag", want.alt_flag, out_key.alt_flag);
                compare_field("special_flag", want.special_flag, out_key.special_flag);
                compare_field("xterm_modifiers", want.xterm_modifiers,
                              out_key.xterm_modifiers);
                compare_field("sequence_length", want.sequence_length,
                              out_key.sequence_length);
            end
        end
    end

    task automatic push_beat(input logic op, input logic [7:0] b);
        tksd_pkg::t_in_item beat;
        beat.opcode = op;
        beat.data_byte = b;
        tx_beats.push_back(beat);
        beats_queued++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        push_beat(tksd_pkg::OP_BYTE, b);
    endtask

    task automatic push_ticks(input int n);
        repeat (n) push_beat(tksd_pkg::OP_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    task automatic push_number(input int v, input int pad);
        repeat (pad) push_byte(tksd_pkg::DIGIT_0);
        push_text($sformatf("%0d", v));
    endtask

    task automatic push_csi();
        int mode;
        int r;
        push_byte(tksd_pkg::ESC_BYTE);
        push_byte(tksd_pkg::CSI_BYTE);
        mode = $urandom_range(0, 9);
        if (mode == 1) push_number($urandom_range(0, 999), 0);
        else if (mode == 2) push_number($urandom_range(0, 36), $urandom_range(0, 13));
        else if (mode != 0) push_number($urandom_range(0, 36), 0);
        if ($urandom_range(0, 2) == 0) begin
            push_byte(tksd_pkg::SEP_BYTE);
            if ($urandom_range(0, 5) != 0) push_number($urandom_range(0, 17), 0);
        end
        if ($urandom_range(0, 11) == 0) push_byte(8'($urandom_range(8'h20, 8'h3F)));
        r = $urandom_range(0, 9);
        if (r < 5) push_byte(tksd_pkg::TILDE_BYTE);
        else if (r < 9) push_byte(tksd_pkg::UPPER_A + 8'($urandom_range(0, 25)));
        else push_byte(8'($urandom_range(tksd_pkg::FINAL_LO, tksd_pkg::TILDE_BYTE)));
    endtask

    task automatic push_random_key();
        int pick;
        int span;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        span = (esc_timeout < 30) ? int'(esc_timeout) + 3 : 30;
        if (pick < 20) begin
            do b = 8'($urandom_range(0, 127)); while (b == tksd_pkg::ESC_BYTE);
            push_byte(b);
        end else if (pick < 35) begin
            push_byte(tksd_pkg::ESC_BYTE);
            push_byte(8'($urandom_range(0, 255)));
        end else if (pick < 72) begin
            push_csi();
        end else if (pick < 84) begin
            push_ticks($urandom_range(1, span));
        end else if (pick < 94) begin
            push_byte(tksd_pkg::ESC_BYTE);
            if ($urandom_range(0, 1) == 1) push_byte(tksd_pkg::CSI_BYTE);
            push_ticks($urandom_range(1, span));
        end else begin
            repeat ($urandom_range(1, 20)) push_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_phase(input int beats);
        int stop_at;
        stop_at = beats_queued + beats;
        while (beats_queued < stop_at) push_random_key();
    endtask

    task automatic drain();
        while (beats_taken != beats_queued || keys_due.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_timeout(input tksd_pkg::t_ticks v);
        drain();
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        esc_timeout = v;
    endtask

    initial begin
        logic [7:0] lone_bytes [8];
        logic [7:0] alt_bytes [6];
        string      bodies [16];
        lone_bytes = '{tksd_pkg::NUL_BYTE, tksd_pkg::CTRL_FIRST, tksd_pkg::CTRL_LAST,
                       tksd_pkg::FS_BYTE, tksd_pkg::US_BYTE, tksd_pkg::PRINT_LO,
                       tksd_pkg::PRINT_HI, tksd_pkg::DEL_BYTE};
        alt_bytes = '{tksd_pkg::CTRL_FIRST, tksd_pkg::CTRL_LAST, tksd_pkg::NUL_BYTE,
                      tksd_pkg::ESC_BYTE, 8'hFF, 8'h78};
        bodies = '{"[A", "[1;5C", "[3~", "[0;2~", "[;7~", "[5;~", "[300~", "[2;300~",
                   "[Z", "[x", "[a", "[1!~", "[;;A", "[999999999999~",
                   "[11111111111111", "[15;3H"};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // A lone ESC is held while fewer ticks than the reset timeout have passed.
        push_byte(tksd_pkg::ESC_BYTE);
        push_ticks(40);
        foreach (lone_bytes[i]) push_byte(lone_bytes[i]);
        foreach (alt_bytes[i]) begin
            push_byte(tksd_pkg::ESC_BYTE);
            push_byte(alt_bytes[i]);
        end
        foreach (bodies[i]) begin
            push_byte(tksd_pkg::ESC_BYTE);
            push_text(bodies[i]);
        end
        push_byte(8'hC8);
        push_text("[1;5A~abcdefghi");

        set_timeout('0);
        push_byte(tksd_pkg::ESC_BYTE);
        push_byte(tksd_pkg::CSI_BYTE);
        push_ticks(1);
        push_byte(tksd_pkg::ESC_BYTE);
        push_ticks(1);
        run_phase(250);
        squeeze_req <= 1'b1;

        set_timeout(tksd_pkg::TICK_MAX);
        push_byte(tksd_pkg::ESC_BYTE);
        push_ticks(40);
        push_byte("q");
        run_phase(250);

        set_timeout(20'd1);
        run_phase(250);
        set_timeout(20'd7);
        run_phase(250);
        set_timeout(tksd_pkg::t_ticks'($urandom_range(0, 40)));
        run_phase(250);

        set_timeout(20'd3);
        calm <= 1'b1;
        run_phase(150);
        drain();
        repeat (5) @(posedge clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #(30_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/tksd_pkg.sv
hw/rtl/terminal_key_sequence_decoder.sv
hw/rtl/tksd_checker.sv
sim/tb_top.sv
